>>> sv/mbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_pkg
// Shared types and constants for the multi-button debouncer.
// ----------------------------------------------------------------------------
package mbd_pkg;

    localparam int FUNC_W  = 2;
    localparam int PIN_W   = 4;
    localparam int ID_W    = 2;
    localparam int DELAY_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [DELAY_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [DELAY_W-1:0] DELAY_DEFAULT = 16'd40;

    localparam logic [CFG_IDX_W-1:0] REG_PRESS_DELAY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK          = 2'd0,
        FN_UPDATE        = 2'd1,
        FN_QUERY_PRESS   = 2'd2,
        FN_QUERY_RELEASE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        PH_UP   = 2'd0,
        PH_FALL = 2'd1,
        PH_DOWN = 2'd2,
        PH_RISE = 2'd3
    } t_phase;

    typedef struct packed {
        logic tick;
        logic update;
        logic clr_press;
        logic clr_release;
    } t_lane_ctrl;

endpackage
`default_nettype wire

>>> sv/mbd_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_lane
// One button: four-phase debounce machine, settle timer and event latches.
// ----------------------------------------------------------------------------
module mbd_lane (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mbd_pkg::t_lane_ctrl            i_ctrl,
    input  wire logic                           i_pin_high,
    input  wire logic [mbd_pkg::DELAY_W-1:0]    i_press_delay,
    input  wire logic [mbd_pkg::DELAY_W-1:0]    i_release_delay,
    output logic                                o_press_latch,
    output logic                                o_release_latch
);

    mbd_pkg::t_phase               r_phase, n_phase;
    logic [mbd_pkg::DELAY_W-1:0]   r_elapsed, n_elapsed;
    logic                          r_run, n_run;
    logic                          r_press, n_press;
    logic                          r_release, n_release;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= mbd_pkg::PH_UP;
            r_elapsed <= '0;
            r_run     <= 1'b0;
            r_press   <= 1'b0;
            r_release <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_run     <= n_run;
            r_press   <= n_press;
            r_release <= n_release;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_run     = r_run;
        n_press   = r_press && !i_ctrl.clr_press;
        n_release = r_release && !i_ctrl.clr_release;

        if (i_ctrl.tick) begin
            if (r_run && r_elapsed != mbd_pkg::ELAPSED_MAX) begin
                n_elapsed = r_elapsed + 1'b1;
            end
        end

        if (i_ctrl.update) begin
            case (r_phase)
                mbd_pkg::PH_UP: begin
                    if (!i_pin_high) begin
                        n_run   = 1'b0;
                        n_phase = mbd_pkg::PH_FALL;
                    end
                end
                mbd_pkg::PH_FALL: begin
                    if (!r_run) begin
                        n_run     = 1'b1;
                        n_elapsed = '0;
                    end else if (r_elapsed >= i_press_delay) begin
                        n_run = 1'b0;
                        if (!i_pin_high) begin
                            n_press = 1'b1;
                            n_phase = mbd_pkg::PH_DOWN;
                        end else begin
                            n_phase = mbd_pkg::PH_UP;
                        end
                    end
                end
                mbd_pkg::PH_DOWN: begin
                    if (i_pin_high) begin
                        n_run   = 1'b0;
                        n_phase = mbd_pkg::PH_RISE;
                    end
                end
                mbd_pkg::PH_RISE: begin
                    if (!r_run) begin
                        n_run     = 1'b1;
                        n_elapsed = '0;
                    end else if (r_elapsed >= i_release_delay) begin
                        n_run = 1'b0;
                        if (i_pin_high) begin
                            n_release = 1'b1;
                            n_phase   = mbd_pkg::PH_UP;
                        end else begin
                            n_phase = mbd_pkg::PH_DOWN;
                        end
                    end
                end
                default: begin
                    n_phase = mbd_pkg::PH_UP;
                end
            endcase
        end
    end

    assign o_press_latch   = r_press;
    assign o_release_latch = r_release;

endmodule
`default_nettype wire

>>> sv/mbd_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbd_merge
// Combines the lane latches for a query and holds the result register.
// ----------------------------------------------------------------------------
module mbd_merge #(
    parameter int BUTTONS = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire logic                        i_sel_release,
    input  wire logic [BUTTONS-1:0]          i_press_vec,
    input  wire logic [BUTTONS-1:0]          i_release_vec,
    input  wire logic                        i_out_ready,
    output logic                             o_out_valid,
    output logic                             o_found,
    output logic [mbd_pkg::ID_W-1:0]         o_button_id
);

    logic [BUTTONS-1:0]         vec;
    logic                       single;
    logic [mbd_pkg::ID_W-1:0]   who;
    logic                       r_valid;
    logic                       r_found;
    logic [mbd_pkg::ID_W-1:0]   r_id;

    always_comb begin
        vec    = i_sel_release ? i_release_vec : i_press_vec;
        single = (vec != '0) && ((vec & (vec - 1'b1)) == '0);
        who    = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            if (vec[i]) begin
                who = who | mbd_pkg::ID_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_found <= single;
            r_id    <= single ? who : '0;
        end
    end

    assign o_out_valid = r_valid;
    assign o_found     = r_found;
    assign o_button_id = r_id;

endmodule
`default_nettype wire

>>> sv/multi_button_debouncer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_button_debouncer
// Debounces BUTTONS active-low buttons, one lane per button, with a merge
// stage that answers press and release queries.
//
// Input channel (i_in_valid / o_in_ready): one item per transfer: a tick,
// an update with a pin sample, or a press or release query. An item is
// taken every cycle as long as the result register is empty or being read.
// Ticks and updates act on all lanes in the transfer cycle and give no
// result. A query clears the matching latches in that cycle and its result
// appears on o_out_valid in the cycle after. Throughput: one item per cycle
// while the output is not stalled, set by the single result register.
// Output channel (o_out_valid / i_out_ready): while the receiver stalls the
// result is held and only that one result is buffered; input is then
// refused until the result is taken.
// Configuration: i_cfg_we writes press delay (index 0) or release delay
// (index 1), both 40 after reset. Reset puts every button up, timers idle,
// latches clear, and empties the result register.
// ----------------------------------------------------------------------------
module multi_button_debouncer #(
    parameter int BUTTONS = 4
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [mbd_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [mbd_pkg::FUNC_W-1:0]      i_func,
    input  wire logic [mbd_pkg::PIN_W-1:0]       i_pin_levels,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_found,
    output logic [mbd_pkg::ID_W-1:0]             o_button_id
);

    logic [mbd_pkg::DELAY_W-1:0] r_press_delay;
    logic [mbd_pkg::DELAY_W-1:0] r_release_delay;
    logic                        in_xfer;
    mbd_pkg::t_func              func;
    mbd_pkg::t_lane_ctrl         ctrl;
    logic [BUTTONS-1:0]          press_vec;
    logic [BUTTONS-1:0]          release_vec;
    logic                        is_query;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_delay   <= mbd_pkg::DELAY_DEFAULT;
            r_release_delay <= mbd_pkg::DELAY_DEFAULT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mbd_pkg::REG_PRESS_DELAY:   r_press_delay   <= i_cfg_data;
                mbd_pkg::REG_RELEASE_DELAY: r_release_delay <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = !o_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign func       = mbd_pkg::t_func'(i_func);

    always_comb begin
        ctrl.tick        = in_xfer && (func == mbd_pkg::FN_TICK);
        ctrl.update      = in_xfer && (func == mbd_pkg::FN_UPDATE);
        ctrl.clr_press   = in_xfer && (func == mbd_pkg::FN_QUERY_PRESS);
        ctrl.clr_release = in_xfer && (func == mbd_pkg::FN_QUERY_RELEASE);
        is_query         = ctrl.clr_press || ctrl.clr_release;
    end

    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        logic pin_high;
        if (g < mbd_pkg::PIN_W) begin : g_pin
            assign pin_high = i_pin_levels[g];
        end else begin : g_nopin
            assign pin_high = 1'b0;
        end

        mbd_lane u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctrl          (ctrl),
            .i_pin_high      (pin_high),
            .i_press_delay   (r_press_delay),
            .i_release_delay (r_release_delay),
            .o_press_latch   (press_vec[g]),
            .o_release_latch (release_vec[g])
        );
    end

    mbd_merge #(
        .BUTTONS (BUTTONS)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (is_query),
        .i_sel_release (ctrl.clr_release),
        .i_press_vec   (press_vec),
        .i_release_vec (release_vec),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_button_id   (o_button_id)
    );

    a_query_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_query |=> o_out_valid)
        else $error("query transfer did not produce a result");

    a_press_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.clr_press |=> (press_vec == '0))
        else $error("press latches not cleared by press query");

    a_release_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.clr_release |=> (release_vec == '0))
        else $error("release latches not cleared by release query");

    a_id_zero_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_button_id == '0))
        else $error("button id nonzero without a found button");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-button debouncer. A short scripted part
// walks the press and release paths, multi-latch queries, a long settle
// delay and the zero-delay path. It is followed by random phases of held
// pin patterns with occasional bounces, ticks and queries, under several
// delay settings and idle patterns. Scripted query results are compared with
// fixed expected values, random ones with an in-bench prediction of all button lanes.
// ----------------------------------------------------------------------------
module tb_top;
    import mbd_pkg::*;

    localparam int BUTTONS      = 4;
    localparam int SETTLE_CYC   = 4;
    localparam int HOLD_CYC     = 300;
    localparam int MAX_GAP      = 40;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SCRIPT_ROWS  = 35;
    localparam logic [DELAY_W-1:0] LONG_DLY = 16'd100;

    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] id;
    } t_report;

    typedef struct {
        t_func              fn;
        logic [PIN_W-1:0]   pins;
        int                 reps;
        bit                 fixed;
        logic               e_found;
        logic [ID_W-1:0]    e_id;
    } t_stim_row;

    // rows 0..23 at reset delays, 24..29 at a long delay, 30..34 at zero
    t_stim_row script [0:SCRIPT_ROWS-1] = '{
        '{FN_QUERY_PRESS,   4'b1111,     1, 1'b1, 1'b0, 2'd0},
        '{FN_QUERY_RELEASE, 4'b0000,     1, 1'b1, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1110,     1, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1110,     1, 1'b0, 1'b0, 2'd0},
        '{FN_TICK,          4'b0000,    40, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1110,     1, 1'b0, 1'b0, 2'd0},
        '{FN_QUERY_PRESS,   4'b0000,     1, 1'b1, 1'b1, 2'd0},
        '{FN_UPDATE,        4'b1111,     1, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1111,     1, 1'b0, 1'b0, 2'd0},
        '{FN_TICK,          4'b1111,    39, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1111,     1, 1'b0, 1'b0, 2'd0},
        '{FN_TICK,          4'b0101,     1, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1111,     1, 1'b0, 1'b0, 2'd0},
        '{FN_QUERY_RELEASE, 4'b1111,     1, 1'b1, 1'b1, 2'd0},
        '{FN_UPDATE,        4'b0000,     1, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b0000,     1, 1'b0, 1'b0, 2'd0},
        '{FN_TICK,          4'b1010,    40, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b0110,     1, 1'b0, 1'b0, 2'd0},
        '{FN_QUERY_PRESS,   4'b0110,     1, 1'b1, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1111,     1, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1111,     1, 1'b0, 1'b0, 2'd0},
        '{FN_TICK,          4'b0000,    40, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1000,     1, 1'b0, 1'b0, 2'd0},
        '{FN_QUERY_RELEASE, 4'b0000,     1, 1'b1, 1'b1, 2'd3},
        '{FN_UPDATE,        4'b1101,     1, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1101,     1, 1'b0, 1'b0, 2'd0},
        '{FN_TICK,          4'b0010,   100, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1101,     1, 1'b0, 1'b0, 2'd0},
        '{FN_QUERY_PRESS,   4'b1101,     1, 1'b1, 1'b1, 2'd1},
        '{FN_QUERY_RELEASE, 4'b1101,     1, 1'b1, 1'b1, 2'd0},
        '{FN_UPDATE,        4'b1011,     1, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1011,     1, 1'b0, 1'b0, 2'd0},
        '{FN_UPDATE,        4'b1011,     1, 1'b0, 1'b0, 2'd0},
        '{FN_QUERY_PRESS,   4'b1011,     1, 1'b1, 1'b1, 2'd2},
        '{FN_QUERY_RELEASE, 4'b1011,     1, 1'b1, 1'b1, 2'd1}
    };

    logic                 i_clk;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_ready;
    logic [FUNC_W-1:0]    i_func       = '0;
    logic [PIN_W-1:0]     i_pin_levels = '0;
    logic                 o_out_valid;
    logic                 i_out_ready  = 1'b0;
    logic                 o_found;
    logic [ID_W-1:0]      o_button_id;

    multi_button_debouncer #(.BUTTONS(BUTTONS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_pin_levels (i_pin_levels),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_found      (o_found),
        .o_button_id  (o_button_id)
    );

    // predicted per-button state
    t_phase             btn_phase   [BUTTONS];
    logic [DELAY_W-1:0] btn_elapsed [BUTTONS];
    bit                 btn_armed   [BUTTONS];
    bit                 press_seen  [BUTTONS];
    bit                 release_seen[BUTTONS];
    logic [DELAY_W-1:0] press_dly   = DELAY_DEFAULT;
    logic [DELAY_W-1:0] release_dly = DELAY_DEFAULT;

    t_report          expected_reports[$];
    logic [PIN_W-1:0] held_pins = '1;

    int errors         = 0;
    int items_sent     = 0;
    int reports_seen   = 0;
    int reports_named  = 0;
    int refused_cycles = 0;
    int settings_used  = 1;
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int holds_asked    = 0;
    int holds_granted  = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // settle timer: arm on first call, report expiry once elapsed reaches lim
    function automatic bit settle_expired(input int b, input logic [DELAY_W-1:0] lim);
        if (!btn_armed[b]) begin
            btn_armed[b]   = 1'b1;
            btn_elapsed[b] = '0;
            return 1'b0;
        end
        if (btn_elapsed[b] >= lim) begin
            btn_armed[b] = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void debounce_step(input t_func fn, input logic [PIN_W-1:0] pins,
                                          output bit gives, output t_report rep);
        int  hits;
        int  who;
        bit  high;
        bit  hit;
        gives = 1'b0;
        rep   = '0;
        hits  = 0;
        who   = 0;
        case (fn)
            FN_TICK: begin
                for (int b = 0; b < BUTTONS; b++)
                    if (btn_armed[b] && btn_elapsed[b] != ELAPSED_MAX)
                        btn_elapsed[b] = btn_elapsed[b] + 1'b1;
            end
            FN_UPDATE: begin
                for (int b = 0; b < BUTTONS; b++) begin
                    high = pins[b];
                    case (btn_phase[b])
                        PH_UP: begin
                            if (!high) begin
                                btn_armed[b] = 1'b0;
                                btn_phase[b] = PH_FALL;
                            end
                        end
                        PH_FALL: begin
                            if (settle_expired(b, press_dly)) begin
                                if (!high) begin
                                    press_seen[b] = 1'b1;
                                    btn_phase[b]  = PH_DOWN;
                                end else begin
                                    btn_phase[b] = PH_UP;
                                end
                            end
                        end
                        PH_DOWN: begin
                            if (high) begin
                                btn_armed[b] = 1'b0;
                                btn_phase[b] = PH_RISE;
                            end
                        end
                        default: begin
                            if (settle_expired(b, release_dly)) begin
                                if (high) begin
                                    release_seen[b] = 1'b1;
                                    btn_phase[b]    = PH_UP;
                                end else begin
                                    btn_phase[b] = PH_DOWN;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                gives = 1'b1;
                for (int b = 0; b < BUTTONS; b++) begin
                    hit = (fn == FN_QUERY_PRESS) ? press_seen[b] : release_seen[b];
                    if (hit) begin
                        hits++;
                        who = b;
                    end
                    if (fn == FN_QUERY_PRESS) press_seen[b] = 1'b0;
                    else release_seen[b] = 1'b0;
                end
                if (hits == 1) begin
                    rep.found = 1'b1;
                    rep.id    = ID_W'(who);
                end
            end
        endcase
    endfunction

    task automatic offer_item(input t_func fn, input logic [PIN_W-1:0] pins,
                              input bit fixed, input t_report fixed_rep);
        int      gap;
        bit      gives;
        t_report rep;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= fn;
        i_pin_levels <= pins;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        debounce_step(fn, pins, gives, rep);
        if (gives) expected_reports.push_back(fixed ? fixed_rep : rep);
        items_sent++;
    endtask

    // called in the cycle of the last transfer; drops valid and lets the block go idle
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic program_delays(input logic [DELAY_W-1:0] pd, input logic [DELAY_W-1:0] rd);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_PRESS_DELAY;
        i_cfg_data  <= pd;
        @(posedge i_clk);
        i_cfg_index <= REG_RELEASE_DELAY;
        i_cfg_data  <= rd;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        press_dly   = pd;
        release_dly = rd;
        settings_used++;
    endtask

    task automatic walk_script(input int lo, input int hi);
        t_report want;
        for (int r = lo; r <= hi; r++) begin
            want.found = script[r].e_found;
            want.id    = script[r].e_id;
            repeat (script[r].reps)
                offer_item(script[r].fn, script[r].pins, script[r].fixed, want);
        end
    endtask

    // mostly stable pin patterns with slow changes, some bounce and some noise
    task automatic random_traffic(input int n);
        int               r;
        t_func            fn;
        logic [PIN_W-1:0] pins;
        for (int k = 0; k < n; k++) begin
            r    = $urandom_range(99);
            pins = PIN_W'($urandom);
            if (r < 8) begin
                fn = t_func'($urandom_range(3));
            end else if (r < 40) begin
                fn = FN_TICK;
            end else if (r < 82) begin
                fn = FN_UPDATE;
                if ($urandom_range(99) < 10) held_pins[$urandom_range(PIN_W-1)] ^= 1'b1;
                if ($urandom_range(99) >= 6) pins = held_pins;
            end else begin
                fn = $urandom_range(1) ? FN_QUERY_PRESS : FN_QUERY_RELEASE;
            end
            offer_item(fn, pins, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (holds_granted != holds_asked) begin
            holds_granted <= holds_granted + 1;
            hold_left     <= HOLD_CYC;
            i_out_ready   <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && i_in_valid && !o_in_ready) refused_cycles++;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            reports_seen++;
            if (o_found === 1'b1) reports_named++;
            if (expected_reports.size() == 0) begin
                $error("result transfer with none pending: found %0d button_id %0d",
                       o_found, o_button_id);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_found);
                    errors++;
                end
                if (o_button_id !== want.id) begin
                    $error("button_id: expected %0d, actual %0d", want.id, o_button_id);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int b = 0; b < BUTTONS; b++) begin
            btn_phase[b]    = PH_UP;
            btn_elapsed[b]  = '0;
            btn_armed[b]    = 1'b0;
            press_seen[b]   = 1'b0;
            release_seen[b] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        walk_script(0, 23);
        quiesce();
        program_delays(LONG_DLY, LONG_DLY);
        walk_script(24, 29);
        quiesce();
        program_delays('0, '0);
        walk_script(30, SCRIPT_ROWS-1);
        quiesce();

        program_delays(16'd2, 16'd3);
        random_traffic(120);
        quiesce();

        sender_idle_pct = 78;
        program_delays('0, '0);
        random_traffic(100);
        quiesce();

        sender_idle_pct = 0;
        recv_stall_pct  = 78;
        program_delays(16'd4, 16'd1);
        random_traffic(100);
        quiesce();

        sender_idle_pct = 28;
        recv_stall_pct  = 28;
        program_delays(DELAY_W'($urandom_range(6)), DELAY_W'($urandom_range(6)));
        random_traffic(120);
        quiesce();

        // long receiver hold-off while the sender keeps offering
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        program_delays(16'd1, 16'd1);
        holds_asked++;
        random_traffic(120);
        quiesce();

        $display("Run covered %0d items over %0d delay settings;", items_sent, settings_used);
        $display("%0d results checked, %0d named a button, input refused for %0d cycles.",
                 reports_seen, reports_named, refused_cycles);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
